// ===== rtl/asf_pkg.sv =====
// Shared widths, reset values, register indexes and pipeline context for the arrive steering block.
`default_nettype none

package asf_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 24;
    localparam int DIFF_W    = DATA_W + 1;
    localparam int STEER_W   = DATA_W + 2;
    localparam int RAD_W     = 2 * STEER_W;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DEN_W     = STEER_W;
    localparam int QUO_W     = DATA_W;
    localparam int NUM_W     = DEN_W + QUO_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] MAX_SPEED_RST = DATA_W'(4 << FRAC_BITS);
    localparam logic [DATA_W-1:0] MAX_FORCE_RST = DATA_W'((1 << FRAC_BITS) / 4);
    localparam logic [DATA_W-1:0] SLOW_DIST_RST = DATA_W'(100 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_SPEED = 2'd0,
        CFG_MAX_FORCE = 2'd1,
        CFG_SLOW_DIST = 2'd2
    } cfg_idx_t;

    // Values that ride along with an item through the arithmetic units.
    typedef struct packed {
        logic signed [DATA_W-1:0]  vx;
        logic signed [DATA_W-1:0]  vy;
        logic                      neg_x;
        logic                      neg_y;
        logic [DIFF_W-1:0]         mag_x;
        logic [DIFF_W-1:0]         mag_y;
        logic [DIFF_W-1:0]         distance;
        logic                      near;
        logic                      at_target;
        logic [DATA_W-1:0]         speed;
        logic signed [STEER_W-1:0] sx;
        logic signed [STEER_W-1:0] sy;
        logic                      over;
    } ctx_t;

endpackage

`default_nettype wire

// ===== rtl/asf_in_if.sv =====
// Input channel: agent position, velocity and target point.
`default_nettype none

interface asf_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [asf_pkg::DATA_W-1:0]  pos_x;
    logic signed [asf_pkg::DATA_W-1:0]  pos_y;
    logic signed [asf_pkg::DATA_W-1:0]  vel_x;
    logic signed [asf_pkg::DATA_W-1:0]  vel_y;
    logic signed [asf_pkg::DATA_W-1:0]  target_x;
    logic signed [asf_pkg::DATA_W-1:0]  target_y;

    modport source (
        output valid, output pos_x, output pos_y, output vel_x, output vel_y,
        output target_x, output target_y, input ready
    );
    modport sink (
        input valid, input pos_x, input pos_y, input vel_x, input vel_y,
        input target_x, input target_y, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/asf_out_if.sv =====
// Output channel: steering force.
`default_nettype none

interface asf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [asf_pkg::DATA_W-1:0]  force_x;
    logic signed [asf_pkg::DATA_W-1:0]  force_y;

    modport source (output valid, output force_x, output force_y, input ready);
    modport sink (input valid, input force_x, input force_y, output ready);
endinterface

`default_nettype wire

// ===== rtl/arrive_steering_force.sv =====
// Arrive steering force: fully pipelined datapath from agent state to limited steering force.
//
//   channel   direction  payload                                   handshake
//   agent     in         pos_x/y, vel_x/y, target_x/y (s24 Q16.8)  valid/ready
//   steer     out        force_x/y (s24 Q16.8, saturated)          valid/ready
//   cfg       in         cfg_index, cfg_wdata                      cfg_we, no wait
//
// One transaction is accepted per cycle while the output is not stalled; the pipeline
// depth is set by two 26-stage square-root pipelines and three 24-stage dividers.
// Reset clears all valid bits and loads the register reset values; there is no sweep.
// When the output register holds a result that is not taken, the whole pipeline
// freezes in place, so nothing is dropped or repeated.
`default_nettype none

module arrive_steering_force (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [asf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [asf_pkg::DATA_W-1:0]      cfg_wdata,
    asf_in_if.sink                               agent,
    asf_out_if.source                            steer
);

    function automatic logic signed [asf_pkg::DATA_W-1:0] sat_data(
        input logic signed [asf_pkg::STEER_W-1:0] v
    );
        logic [2:0] top;
        top = v[asf_pkg::STEER_W-1 -: 3];
        if (top == 3'b000 || top == 3'b111)
            return v[asf_pkg::DATA_W-1:0];
        else if (v[asf_pkg::STEER_W-1])
            return {1'b1, {(asf_pkg::DATA_W-1){1'b0}}};
        else
            return {1'b0, {(asf_pkg::DATA_W-1){1'b1}}};
    endfunction

    // Configuration registers
    logic [asf_pkg::DATA_W-1:0] max_speed_reg;
    logic [asf_pkg::DATA_W-1:0] max_force_reg;
    logic [asf_pkg::DATA_W-1:0] slow_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= asf_pkg::MAX_SPEED_RST;
            max_force_reg <= asf_pkg::MAX_FORCE_RST;
            slow_dist_reg <= asf_pkg::SLOW_DIST_RST;
        end
        else if (cfg_we)
        begin
            case (asf_pkg::cfg_idx_t'(cfg_index))
                asf_pkg::CFG_MAX_SPEED: max_speed_reg <= cfg_wdata;
                asf_pkg::CFG_MAX_FORCE: max_force_reg <= cfg_wdata;
                asf_pkg::CFG_SLOW_DIST: slow_dist_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic en;
    logic out_vld_reg;

    assign en          = !out_vld_reg || steer.ready;
    assign agent.ready = en;

    // Stage 1: offset to the target.
    logic                                s1_vld_reg;
    logic signed [asf_pkg::DIFF_W-1:0]   s1_dx_reg, s1_dx_next;
    logic signed [asf_pkg::DIFF_W-1:0]   s1_dy_reg, s1_dy_next;
    logic signed [asf_pkg::DATA_W-1:0]   s1_vx_reg, s1_vy_reg;

    assign s1_dx_next = {agent.target_x[asf_pkg::DATA_W-1], agent.target_x}
                      - {agent.pos_x[asf_pkg::DATA_W-1], agent.pos_x};
    assign s1_dy_next = {agent.target_y[asf_pkg::DATA_W-1], agent.target_y}
                      - {agent.pos_y[asf_pkg::DATA_W-1], agent.pos_y};

    // Stage 2: squares and magnitudes of the offset.
    logic                                  s2_vld_reg;
    logic signed [2*asf_pkg::DIFF_W-1:0]   dx_sq, dy_sq;
    logic [2*asf_pkg::DIFF_W-1:0]          s2_dx2_reg, s2_dy2_reg;
    asf_pkg::ctx_t                         s2_ctx_reg, s2_ctx_next;

    always_comb
    begin
        dx_sq = s1_dx_reg * s1_dx_reg;
        dy_sq = s1_dy_reg * s1_dy_reg;
        s2_ctx_next       = '0;
        s2_ctx_next.vx    = s1_vx_reg;
        s2_ctx_next.vy    = s1_vy_reg;
        s2_ctx_next.neg_x = s1_dx_reg[asf_pkg::DIFF_W-1];
        s2_ctx_next.neg_y = s1_dy_reg[asf_pkg::DIFF_W-1];
        s2_ctx_next.mag_x = s1_dx_reg[asf_pkg::DIFF_W-1] ? asf_pkg::DIFF_W'(-s1_dx_reg)
                                                          : s1_dx_reg;
        s2_ctx_next.mag_y = s1_dy_reg[asf_pkg::DIFF_W-1] ? asf_pkg::DIFF_W'(-s1_dy_reg)
                                                          : s1_dy_reg;
    end

    // Stage 3: squared distance.
    logic                           s3_vld_reg;
    logic [asf_pkg::RAD_W-1:0]      s3_rad_reg, s3_rad_next;
    asf_pkg::ctx_t                  s3_ctx_reg;

    assign s3_rad_next = {2'b00, s2_dx2_reg} + {2'b00, s2_dy2_reg};

    logic                           q1_vld;
    logic [asf_pkg::ROOT_W-1:0]     q1_root;
    asf_pkg::ctx_t                  q1_ctx;

    asf_isqrt u_dist_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_rad   (s3_rad_reg),
        .in_ctx   (s3_ctx_reg),
        .out_vld  (q1_vld),
        .out_root (q1_root),
        .out_ctx  (q1_ctx)
    );

    // Stage 4: ramp numerator. Inside the slowing distance the ramp is below
    // max_speed; outside it the ramp is discarded in favor of max_speed.
    logic                                           s4_vld_reg;
    logic [asf_pkg::DATA_W+asf_pkg::DIFF_W-1:0]     ramp_prod;
    logic [asf_pkg::NUM_W-1:0]                      s4_num_reg, s4_num_next;
    asf_pkg::ctx_t                                  s4_ctx_reg, s4_ctx_next;

    always_comb
    begin
        s4_ctx_next           = q1_ctx;
        s4_ctx_next.distance  = q1_root[asf_pkg::DIFF_W-1:0];
        s4_ctx_next.near      = q1_root[asf_pkg::DIFF_W-1:0] < {1'b0, slow_dist_reg};
        s4_ctx_next.at_target = q1_root == '0;
        ramp_prod             = max_speed_reg * q1_root[asf_pkg::DIFF_W-1:0];
        s4_num_next           = {1'b0, ramp_prod};
    end

    logic                           d1_vld;
    logic [asf_pkg::QUO_W-1:0]      d1_q;
    asf_pkg::ctx_t                  d1_ctx;

    asf_div2 u_ramp_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_num_a (s4_num_reg),
        .in_num_b ('0),
        .in_den   ({2'b00, slow_dist_reg}),
        .in_ctx   (s4_ctx_reg),
        .out_vld  (d1_vld),
        .out_q_a  (d1_q),
        .out_q_b  (),
        .out_ctx  (d1_ctx)
    );

    // Stage 5: clipped speed.
    logic             s5_vld_reg;
    asf_pkg::ctx_t    s5_ctx_reg, s5_ctx_next;

    always_comb
    begin
        s5_ctx_next       = '0;
        s5_ctx_next.vx    = d1_ctx.vx;
        s5_ctx_next.vy    = d1_ctx.vy;
        s5_ctx_next.neg_x = d1_ctx.neg_x;
        s5_ctx_next.neg_y = d1_ctx.neg_y;
        s5_ctx_next.mag_x = d1_ctx.mag_x;
        s5_ctx_next.mag_y = d1_ctx.mag_y;
        s5_ctx_next.distance  = d1_ctx.distance;
        s5_ctx_next.at_target = d1_ctx.at_target;
        s5_ctx_next.speed = d1_ctx.near ? d1_q : max_speed_reg;
    end

    // Stage 6: desired velocity numerators.
    logic                                           s6_vld_reg;
    logic [asf_pkg::DATA_W+asf_pkg::DIFF_W-1:0]     des_prod_x, des_prod_y;
    logic [asf_pkg::NUM_W-1:0]                      s6_num_x_reg, s6_num_y_reg;
    logic [asf_pkg::DEN_W-1:0]                      s6_den_reg;
    asf_pkg::ctx_t                                  s6_ctx_reg, s6_ctx_next;

    always_comb
    begin
        des_prod_x            = s5_ctx_reg.mag_x * s5_ctx_reg.speed;
        des_prod_y            = s5_ctx_reg.mag_y * s5_ctx_reg.speed;
        s6_ctx_next           = '0;
        s6_ctx_next.vx        = s5_ctx_reg.vx;
        s6_ctx_next.vy        = s5_ctx_reg.vy;
        s6_ctx_next.neg_x     = s5_ctx_reg.neg_x;
        s6_ctx_next.neg_y     = s5_ctx_reg.neg_y;
        s6_ctx_next.at_target = s5_ctx_reg.at_target;
    end

    logic                           d2_vld;
    logic [asf_pkg::QUO_W-1:0]      d2_qx, d2_qy;
    asf_pkg::ctx_t                  d2_ctx;

    asf_div2 u_desired_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .in_num_a (s6_num_x_reg),
        .in_num_b (s6_num_y_reg),
        .in_den   (s6_den_reg),
        .in_ctx   (s6_ctx_reg),
        .out_vld  (d2_vld),
        .out_q_a  (d2_qx),
        .out_q_b  (d2_qy),
        .out_ctx  (d2_ctx)
    );

    // Stage 7: steer = desired - velocity. On the target the desired velocity is zero.
    logic                                s7_vld_reg;
    logic signed [asf_pkg::STEER_W-1:0]  des_x, des_y;
    asf_pkg::ctx_t                       s7_ctx_reg, s7_ctx_next;

    always_comb
    begin
        if (d2_ctx.at_target)
        begin
            des_x = '0;
            des_y = '0;
        end
        else
        begin
            des_x = d2_ctx.neg_x ? -$signed({2'b00, d2_qx}) : $signed({2'b00, d2_qx});
            des_y = d2_ctx.neg_y ? -$signed({2'b00, d2_qy}) : $signed({2'b00, d2_qy});
        end
        s7_ctx_next    = '0;
        s7_ctx_next.sx = des_x - {{2{d2_ctx.vx[asf_pkg::DATA_W-1]}}, d2_ctx.vx};
        s7_ctx_next.sy = des_y - {{2{d2_ctx.vy[asf_pkg::DATA_W-1]}}, d2_ctx.vy};
    end

    // Stage 8: squares of the steer and of the force limit.
    logic                                  s8_vld_reg;
    logic signed [asf_pkg::RAD_W-1:0]      sx_sq, sy_sq;
    logic [asf_pkg::RAD_W-1:0]             s8_sx2_reg, s8_sy2_reg;
    logic [2*asf_pkg::DATA_W-1:0]          s8_mf2_reg, s8_mf2_next;
    asf_pkg::ctx_t                         s8_ctx_reg, s8_ctx_next;

    always_comb
    begin
        sx_sq             = s7_ctx_reg.sx * s7_ctx_reg.sx;
        sy_sq             = s7_ctx_reg.sy * s7_ctx_reg.sy;
        s8_mf2_next       = max_force_reg * max_force_reg;
        s8_ctx_next       = '0;
        s8_ctx_next.sx    = s7_ctx_reg.sx;
        s8_ctx_next.sy    = s7_ctx_reg.sy;
        s8_ctx_next.mag_x = s7_ctx_reg.sx[asf_pkg::STEER_W-1]
                          ? asf_pkg::DIFF_W'(-s7_ctx_reg.sx)
                          : asf_pkg::DIFF_W'(s7_ctx_reg.sx);
        s8_ctx_next.mag_y = s7_ctx_reg.sy[asf_pkg::STEER_W-1]
                          ? asf_pkg::DIFF_W'(-s7_ctx_reg.sy)
                          : asf_pkg::DIFF_W'(s7_ctx_reg.sy);
    end

    // Stage 9: squared steer length; the limit test runs beside the root.
    logic                           s9_vld_reg;
    logic [asf_pkg::RAD_W-1:0]      s9_len2_reg, s9_len2_next;
    logic [2*asf_pkg::DATA_W-1:0]   s9_mf2_reg;
    asf_pkg::ctx_t                  s9_ctx_reg;
    asf_pkg::ctx_t                  q2_ctx_in;

    assign s9_len2_next = s8_sx2_reg + s8_sy2_reg;

    always_comb
    begin
        q2_ctx_in      = s9_ctx_reg;
        q2_ctx_in.over = s9_len2_reg
                       > {{(asf_pkg::RAD_W - 2*asf_pkg::DATA_W){1'b0}}, s9_mf2_reg};
    end

    logic                           q2_vld;
    logic [asf_pkg::ROOT_W-1:0]     q2_root;
    asf_pkg::ctx_t                  q2_ctx;

    asf_isqrt u_len_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s9_vld_reg),
        .in_rad   (s9_len2_reg),
        .in_ctx   (q2_ctx_in),
        .out_vld  (q2_vld),
        .out_root (q2_root),
        .out_ctx  (q2_ctx)
    );

    // Stage 10: force scaling numerators.
    logic                                           s10_vld_reg;
    logic [asf_pkg::DATA_W+asf_pkg::DIFF_W-1:0]     f_prod_x, f_prod_y;
    logic [asf_pkg::NUM_W-1:0]                      s10_num_x_reg, s10_num_y_reg;
    logic [asf_pkg::DEN_W-1:0]                      s10_den_reg;
    asf_pkg::ctx_t                                  s10_ctx_reg, s10_ctx_next;

    always_comb
    begin
        f_prod_x          = q2_ctx.mag_x * max_force_reg;
        f_prod_y          = q2_ctx.mag_y * max_force_reg;
        s10_ctx_next      = '0;
        s10_ctx_next.sx   = q2_ctx.sx;
        s10_ctx_next.sy   = q2_ctx.sy;
        s10_ctx_next.over = q2_ctx.over;
    end

    logic                           d3_vld;
    logic [asf_pkg::QUO_W-1:0]      d3_qx, d3_qy;
    asf_pkg::ctx_t                  d3_ctx;

    asf_div2 u_force_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s10_vld_reg),
        .in_num_a (s10_num_x_reg),
        .in_num_b (s10_num_y_reg),
        .in_den   (s10_den_reg),
        .in_ctx   (s10_ctx_reg),
        .out_vld  (d3_vld),
        .out_q_a  (d3_qx),
        .out_q_b  (d3_qy),
        .out_ctx  (d3_ctx)
    );

    // Output stage: pick limited or raw steer and saturate.
    logic signed [asf_pkg::STEER_W-1:0]  fin_x, fin_y;
    logic signed [asf_pkg::DATA_W-1:0]   force_x_reg, force_x_next;
    logic signed [asf_pkg::DATA_W-1:0]   force_y_reg, force_y_next;

    always_comb
    begin
        if (d3_ctx.over)
        begin
            fin_x = d3_ctx.sx[asf_pkg::STEER_W-1] ? -$signed({2'b00, d3_qx})
                                                   : $signed({2'b00, d3_qx});
            fin_y = d3_ctx.sy[asf_pkg::STEER_W-1] ? -$signed({2'b00, d3_qy})
                                                   : $signed({2'b00, d3_qy});
        end
        else
        begin
            fin_x = d3_ctx.sx;
            fin_y = d3_ctx.sy;
        end
        force_x_next = sat_data(fin_x);
        force_y_next = sat_data(fin_y);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= agent.valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= q1_vld;
            s5_vld_reg  <= d1_vld;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= d2_vld;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= q2_vld;
            out_vld_reg <= d3_vld;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg     <= s1_dx_next;
            s1_dy_reg     <= s1_dy_next;
            s1_vx_reg     <= agent.vel_x;
            s1_vy_reg     <= agent.vel_y;
            s2_dx2_reg    <= unsigned'(dx_sq);
            s2_dy2_reg    <= unsigned'(dy_sq);
            s2_ctx_reg    <= s2_ctx_next;
            s3_rad_reg    <= s3_rad_next;
            s3_ctx_reg    <= s2_ctx_reg;
            s4_num_reg    <= s4_num_next;
            s4_ctx_reg    <= s4_ctx_next;
            s5_ctx_reg    <= s5_ctx_next;
            s6_num_x_reg  <= {1'b0, des_prod_x};
            s6_num_y_reg  <= {1'b0, des_prod_y};
            s6_den_reg    <= {1'b0, s5_ctx_reg.distance};
            s6_ctx_reg    <= s6_ctx_next;
            s7_ctx_reg    <= s7_ctx_next;
            s8_sx2_reg    <= unsigned'(sx_sq);
            s8_sy2_reg    <= unsigned'(sy_sq);
            s8_mf2_reg    <= s8_mf2_next;
            s8_ctx_reg    <= s8_ctx_next;
            s9_len2_reg   <= s9_len2_next;
            s9_mf2_reg    <= s8_mf2_reg;
            s9_ctx_reg    <= s8_ctx_reg;
            s10_num_x_reg <= {1'b0, f_prod_x};
            s10_num_y_reg <= {1'b0, f_prod_y};
            s10_den_reg   <= q2_root;
            s10_ctx_reg   <= s10_ctx_next;
            force_x_reg   <= force_x_next;
            force_y_reg   <= force_y_next;
        end
    end

    assign steer.valid   = out_vld_reg;
    assign steer.force_x = force_x_reg;
    assign steer.force_y = force_y_reg;

endmodule

`default_nettype wire

// ===== rtl/asf_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module asf_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [asf_pkg::RAD_W-1:0]   in_rad,
    input  asf_pkg::ctx_t                    in_ctx,
    output logic                             out_vld,
    output logic [asf_pkg::ROOT_W-1:0]       out_root,
    output asf_pkg::ctx_t                    out_ctx
);

    logic                        vld_reg  [asf_pkg::SQ_STEPS];
    logic [asf_pkg::REM_W-1:0]   rem_reg  [asf_pkg::SQ_STEPS];
    logic [asf_pkg::REM_W-1:0]   rem_next [asf_pkg::SQ_STEPS];
    logic [asf_pkg::ROOT_W-1:0]  root_reg [asf_pkg::SQ_STEPS];
    logic [asf_pkg::ROOT_W-1:0]  root_next[asf_pkg::SQ_STEPS];
    logic [asf_pkg::RAD_W-1:0]   rad_reg  [asf_pkg::SQ_STEPS];
    logic [asf_pkg::RAD_W-1:0]   rad_next [asf_pkg::SQ_STEPS];
    asf_pkg::ctx_t               ctx_reg  [asf_pkg::SQ_STEPS];

    always_comb
    begin
        logic [asf_pkg::REM_W-1:0]   r_src;
        logic [asf_pkg::ROOT_W-1:0]  q_src;
        logic [asf_pkg::RAD_W-1:0]   v_src;
        logic [asf_pkg::REM_W+1:0]   r2;
        logic [asf_pkg::REM_W+1:0]   trial;
        for (int k = 0; k < asf_pkg::SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                r_src = '0;
                q_src = '0;
                v_src = in_rad;
            end
            else
            begin
                r_src = rem_reg[k-1];
                q_src = root_reg[k-1];
                v_src = rad_reg[k-1];
            end
            r2    = {r_src, v_src[asf_pkg::RAD_W-1 -: 2]};
            trial = {{(asf_pkg::REM_W - asf_pkg::ROOT_W){1'b0}}, q_src, 2'b01};
            if (r2 >= trial)
            begin
                rem_next[k]  = asf_pkg::REM_W'(r2 - trial);
                root_next[k] = {q_src[asf_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = asf_pkg::REM_W'(r2);
                root_next[k] = {q_src[asf_pkg::ROOT_W-2:0], 1'b0};
            end
            rad_next[k] = {v_src[asf_pkg::RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < asf_pkg::SQ_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < asf_pkg::SQ_STEPS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 0; k < asf_pkg::SQ_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
            end
            for (int k = 1; k < asf_pkg::SQ_STEPS; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_vld  = vld_reg[asf_pkg::SQ_STEPS-1];
    assign out_root = root_reg[asf_pkg::SQ_STEPS-1];
    assign out_ctx  = ctx_reg[asf_pkg::SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/asf_div2.sv =====
// Pipelined restoring divider, two numerators over one divisor, one quotient bit per stage.
`default_nettype none

module asf_div2 (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [asf_pkg::NUM_W-1:0]   in_num_a,
    input  wire logic [asf_pkg::NUM_W-1:0]   in_num_b,
    input  wire logic [asf_pkg::DEN_W-1:0]   in_den,
    input  asf_pkg::ctx_t                    in_ctx,
    output logic                             out_vld,
    output logic [asf_pkg::QUO_W-1:0]        out_q_a,
    output logic [asf_pkg::QUO_W-1:0]        out_q_b,
    output asf_pkg::ctx_t                    out_ctx
);

    // The quotient is known to fit in QUO_W bits, so the upper numerator bits
    // start out below the divisor and only the low bits are brought down.
    function automatic logic [asf_pkg::DEN_W:0] div_step(
        input logic [asf_pkg::DEN_W-1:0] rem,
        input logic                      nb,
        input logic [asf_pkg::DEN_W-1:0] den
    );
        logic [asf_pkg::DEN_W:0] r2;
        r2 = {rem, nb};
        if (r2 >= {1'b0, den})
            return {1'b1, asf_pkg::DEN_W'(r2 - {1'b0, den})};
        else
            return {1'b0, r2[asf_pkg::DEN_W-1:0]};
    endfunction

    logic                        vld_reg   [asf_pkg::DIV_STEPS];
    logic [asf_pkg::DEN_W-1:0]   rem_a_reg [asf_pkg::DIV_STEPS];
    logic [asf_pkg::DEN_W-1:0]   rem_b_reg [asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   low_a_reg [asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   low_b_reg [asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   q_a_reg   [asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   q_b_reg   [asf_pkg::DIV_STEPS];
    logic [asf_pkg::DEN_W-1:0]   den_reg   [asf_pkg::DIV_STEPS];
    asf_pkg::ctx_t               ctx_reg   [asf_pkg::DIV_STEPS];

    logic [asf_pkg::DEN_W-1:0]   rem_a_next[asf_pkg::DIV_STEPS];
    logic [asf_pkg::DEN_W-1:0]   rem_b_next[asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   low_a_next[asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   low_b_next[asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   q_a_next  [asf_pkg::DIV_STEPS];
    logic [asf_pkg::QUO_W-1:0]   q_b_next  [asf_pkg::DIV_STEPS];

    always_comb
    begin
        logic [asf_pkg::DEN_W-1:0] ra;
        logic [asf_pkg::DEN_W-1:0] rb;
        logic [asf_pkg::QUO_W-1:0] la;
        logic [asf_pkg::QUO_W-1:0] lb;
        logic [asf_pkg::QUO_W-1:0] qa;
        logic [asf_pkg::QUO_W-1:0] qb;
        logic [asf_pkg::DEN_W-1:0] d;
        logic [asf_pkg::DEN_W:0]   sa;
        logic [asf_pkg::DEN_W:0]   sb;
        for (int k = 0; k < asf_pkg::DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                ra = in_num_a[asf_pkg::NUM_W-1 -: asf_pkg::DEN_W];
                rb = in_num_b[asf_pkg::NUM_W-1 -: asf_pkg::DEN_W];
                la = in_num_a[asf_pkg::QUO_W-1:0];
                lb = in_num_b[asf_pkg::QUO_W-1:0];
                qa = '0;
                qb = '0;
                d  = in_den;
            end
            else
            begin
                ra = rem_a_reg[k-1];
                rb = rem_b_reg[k-1];
                la = low_a_reg[k-1];
                lb = low_b_reg[k-1];
                qa = q_a_reg[k-1];
                qb = q_b_reg[k-1];
                d  = den_reg[k-1];
            end
            sa = div_step(ra, la[asf_pkg::QUO_W-1], d);
            sb = div_step(rb, lb[asf_pkg::QUO_W-1], d);
            rem_a_next[k] = sa[asf_pkg::DEN_W-1:0];
            rem_b_next[k] = sb[asf_pkg::DEN_W-1:0];
            q_a_next[k]   = {qa[asf_pkg::QUO_W-2:0], sa[asf_pkg::DEN_W]};
            q_b_next[k]   = {qb[asf_pkg::QUO_W-2:0], sb[asf_pkg::DEN_W]};
            low_a_next[k] = {la[asf_pkg::QUO_W-2:0], 1'b0};
            low_b_next[k] = {lb[asf_pkg::QUO_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < asf_pkg::DIV_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < asf_pkg::DIV_STEPS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= in_den;
            ctx_reg[0] <= in_ctx;
            for (int k = 0; k < asf_pkg::DIV_STEPS; k++)
            begin
                rem_a_reg[k] <= rem_a_next[k];
                rem_b_reg[k] <= rem_b_next[k];
                low_a_reg[k] <= low_a_next[k];
                low_b_reg[k] <= low_b_next[k];
                q_a_reg[k]   <= q_a_next[k];
                q_b_reg[k]   <= q_b_next[k];
            end
            for (int k = 1; k < asf_pkg::DIV_STEPS; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    assign out_vld = vld_reg[asf_pkg::DIV_STEPS-1];
    assign out_q_a = q_a_reg[asf_pkg::DIV_STEPS-1];
    assign out_q_b = q_b_reg[asf_pkg::DIV_STEPS-1];
    assign out_ctx = ctx_reg[asf_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire
